/* rtl/lbog_pkg.sv */
// Shared types, constants and codes for the lidar beam occupancy grid update block.
package lbog_pkg;

  // Grid geometry
  localparam int GRID_COLUMNS = 200;
  localparam int GRID_ROWS    = 400;
  localparam int CELL_COUNT   = GRID_COLUMNS * GRID_ROWS;
  localparam int ADDR_W       = $clog2(CELL_COUNT);
  localparam int COL_W        = $clog2(GRID_COLUMNS);
  localparam int ROW_W        = $clog2(GRID_ROWS);

  // Shared multiplier operand widths
  localparam int MUL_AW = 18;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Divider widths: dividend is the magnitude of the scaled offset, divisor the cell size
  localparam int DIV_NW = 21;
  localparam int DIV_DW = 10;

  // Cell value rules
  localparam logic [6:0] CELL_RESET = 7'd50;
  localparam logic [6:0] CELL_DROP  = 7'd20;
  localparam logic [6:0] CELL_KNEE  = 7'd60;
  localparam logic [6:0] CELL_STEP1 = 7'd1;
  localparam logic [6:0] CELL_STEP5 = 7'd5;
  localparam logic [6:0] CELL_MAX   = 7'd100;

  // Result status codes
  localparam logic [2:0] ST_READ     = 3'd0;
  localparam logic [2:0] ST_LOWERED  = 3'd1;
  localparam logic [2:0] ST_RAISED   = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_OUTSIDE  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_CELL_SIZE  = 3'd0;
  localparam logic [2:0] REG_HEIGHT_THR = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X   = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd3;
  localparam logic [2:0] REG_RANGE_LOW  = 3'd4;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd5;

  typedef struct packed {
    logic               mode;
    logic [15:0]        beam_range;
    logic signed [15:0] beam_angle;
    logic signed [15:0] lidar_x;
    logic signed [15:0] lidar_y;
    logic signed [15:0] lidar_yaw;
    logic [16:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic [16:0] cell_index;
    logic [6:0]  cell_value;
    logic [2:0]  status;
  } out_item_t;

  // Divider request from the sequencer
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

endpackage

/* rtl/lbog_mul.sv */
// Shared signed multiplier with a registered product.
module lbog_mul (
  input  logic                                clk,
  input  logic signed [lbog_pkg::MUL_AW-1:0] a,
  input  logic signed [lbog_pkg::MUL_BW-1:0] b,
  output logic signed [lbog_pkg::MUL_PW-1:0] p_r
);
  import lbog_pkg::*;

  // Register every product
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

/* rtl/lbog_div.sv */
// Restoring divider, one quotient bit per cycle.
module lbog_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lbog_pkg::div_req_t          req,
  output logic                        done_r,
  output logic [lbog_pkg::DIV_NW-1:0] quo
);
  import lbog_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // Trial subtract of the next partial remainder
  always_comb begin
    trial = {rem_r, num_r[DIV_NW-1]};
    fits  = trial >= {1'b0, den_r};
  end

  // Control: count the bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift the quotient in as the dividend shifts out
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NW-2:0], fits};
      rem_r <= fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
    end
  end

  assign quo = num_r;

endmodule

/* rtl/lbog_cells.sv */
// Occupancy cell memory with a clearing pass after reset.
module lbog_cells (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lbog_pkg::ADDR_W-1:0] rd_addr,
  output logic [6:0]                  rd_data_r,
  input  logic                        wr_en,
  input  logic [lbog_pkg::ADDR_W-1:0] wr_addr,
  input  logic [6:0]                  wr_data,
  output logic                        clr_busy_r
);
  import lbog_pkg::*;

  logic [6:0]        mem [0:CELL_COUNT-1];
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [6:0]        wd;

  // Clearing pass owns the write port until it ends
  always_comb begin
    we = clr_busy_r || wr_en;
    wa = clr_busy_r ? clr_cnt_r : wr_addr;
    wd = clr_busy_r ? CELL_RESET : wr_data;
  end

  // Sweep every cell once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* rtl/lidar_beam_occupancy_grid_update.sv */
// Top level: beam sequencer, configuration registers and result register.
//
// Usage: pulse start with a beat on in_data while busy is low; the beat is taken at that
// edge. Mode 0 applies one lidar beam to the occupancy grid, mode 1 reads one cell.
// Each beat yields exactly one result beat on out_data, marked by out_valid for one
// cycle; the receiver cannot hold it off.
// Steps from the accepting edge to the result:
//   range rejected or read index past the grid: result registered straight from idle
//   cell read: registered memory read, then the result register
//   beam update: four sines on the shared multiplier, 4 geometry products,
//   two 21-bit divisions, cell read and write
//   Beams that fall outside the grid end after the geometry or either division.
// busy stays high until the result is shown, so one item is in work at a time; a
// new beat may be taken in the cycle that shows the previous result.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write only while idle.
// Reset: registers take their defaults and a clearing pass sets all 80000 cells to 50,
// one cell per cycle; busy stays high until the pass ends.
module lidar_beam_occupancy_grid_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lbog_pkg::in_item_t  in_data,
  output logic                out_valid,
  output lbog_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import lbog_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SINE, S_GEO, S_DIVX, S_DIVY, S_RDWAIT, S_FINISH
  } state_t;

  // Configuration registers
  logic [9:0]         cell_size_r;
  logic [15:0]        thr_r;
  logic signed [15:0] org_x_r;
  logic signed [15:0] org_y_r;
  logic [15:0]        rlo_r;
  logic [15:0]        rhi_r;

  // Sequencer state
  state_t             state_r;
  logic [1:0]         si_r;
  logic [2:0]         ph_r;
  in_item_t           item_r;
  logic [15:0]        t_r;
  logic [15:0]        t2_r;
  logic               neg_r;
  logic signed [16:0] sin_r [0:3];
  logic signed [32:0] reach_r;
  logic               lower_r;
  logic               xneg_r;
  logic [DIV_NW-1:0]  xn_r;
  logic [DIV_NW-1:0]  yn_r;
  logic [COL_W-1:0]   col_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               out_valid_r;
  out_item_t          out_r;

  // Shared units
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] p_r;
  div_req_t                 div_req;
  logic                     div_done;
  logic [DIV_NW-1:0]        quo;
  logic [6:0]               rd_data;
  logic                     wr_en;
  logic [6:0]               new_val;
  logic                     clr_busy;

  // Combinational helpers
  logic [15:0]         ang;
  logic [14:0]         pm;
  logic [15:0]         t_new;
  logic [16:0]         p_sh;
  logic signed [16:0]  sine_val;
  logic signed [16:0]  dx;
  logic signed [16:0]  dy;
  logic signed [51:0]  xnum;
  logic signed [51:0]  ynum;
  logic                range_ok;
  logic [DIV_DW-1:0]   divisor;
  logic [7:0]          up_val;
  logic                out_valid_nxt;

  lbog_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  lbog_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .done_r (div_done),
    .quo    (quo)
  );

  lbog_cells u_cells (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (addr_r),
    .rd_data_r  (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (addr_r),
    .wr_data    (new_val),
    .clr_busy_r (clr_busy)
  );

  // Angle of the current sine, folded into the first quadrant
  always_comb begin
    unique case (si_r)
      2'd0:    ang = item_r.beam_angle + 16'sd16384;
      2'd1:    ang = item_r.beam_angle;
      2'd2:    ang = item_r.lidar_yaw;
      default: ang = item_r.lidar_yaw + 16'sd16384;
    endcase
    pm       = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    t_new    = {pm, 1'b0};
    p_sh     = p_r[31:15];
    sine_val = (p_sh > 17'd32767) ? 17'sd32767 : $signed({2'b00, p_sh[14:0]});
    sine_val = neg_r ? -sine_val : sine_val;
  end

  // Geometry sums on the full products
  always_comb begin
    dx   = 17'(item_r.lidar_x) - 17'(org_x_r);
    dy   = 17'(item_r.lidar_y) - 17'(org_y_r);
    xnum = ($signed({{35{dx[16]}}, dx}) <<< 30) - p_r;
    ynum = ($signed({{35{dy[16]}}, dy}) <<< 30) + p_r;
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SINE) begin
      unique case (ph_r)
        3'd0: begin
          mul_a = $signed({2'b00, t_new});
          mul_b = $signed({18'd0, t_new});
        end
        3'd1: begin
          mul_a = $signed({1'b0, p_sh});
          mul_b = 34'sd153;
        end
        3'd2: begin
          mul_a = $signed({2'b00, t2_r});
          mul_b = 34'sd2611 - $signed({17'd0, p_sh});
        end
        3'd3: begin
          mul_a = $signed({2'b00, t2_r});
          mul_b = 34'sd21167 - $signed({17'd0, p_sh});
        end
        3'd4: begin
          mul_a = $signed({2'b00, t_r});
          mul_b = 34'sd51472 - $signed({17'd0, p_sh});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if (state_r == S_GEO) begin
      unique case (ph_r)
        3'd0: begin
          mul_a = $signed({2'b00, item_r.beam_range});
          mul_b = MUL_BW'(sin_r[0]);
        end
        3'd1: begin
          mul_a = $signed({2'b00, item_r.beam_range});
          mul_b = MUL_BW'(sin_r[1]);
        end
        3'd2: begin
          mul_a = MUL_AW'(sin_r[2]);
          mul_b = $signed({p_r[32], p_r[32:0]});
        end
        3'd3: begin
          mul_a = MUL_AW'(sin_r[3]);
          mul_b = $signed({reach_r[32], reach_r});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // Divider requests: x offset after geometry, y offset after x
  always_comb begin
    divisor          = (cell_size_r == '0) ? DIV_DW'(1) : cell_size_r;
    div_req.divisor  = divisor;
    div_req.start    = 1'b0;
    div_req.dividend = xn_r;
    if (state_r == S_GEO && ph_r == 3'd4 && !xneg_r && !ynum[51]) begin
      div_req.start = 1'b1;
    end else if (state_r == S_DIVX && div_done && quo < DIV_NW'(GRID_COLUMNS)) begin
      div_req.start    = 1'b1;
      div_req.dividend = yn_r;
    end
  end

  // Cell value rules
  always_comb begin
    range_ok = (in_data.beam_range < rhi_r) && (in_data.beam_range > rlo_r);
    if (rd_data < CELL_KNEE) begin
      up_val = {1'b0, rd_data} + {1'b0, CELL_STEP1};
    end else begin
      up_val = {1'b0, rd_data} + {1'b0, CELL_STEP5};
    end
    if (lower_r) begin
      new_val = (rd_data >= CELL_DROP) ? 7'(rd_data - CELL_DROP) : 7'd0;
    end else begin
      new_val = (up_val > {1'b0, CELL_MAX}) ? CELL_MAX : up_val[6:0];
    end
    wr_en = (state_r == S_FINISH) && !item_r.mode;
  end

  // Result strobe: one cycle on every path that ends an item
  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        out_valid_nxt = start && !busy &&
                        (in_data.mode ? (in_data.read_index >= 17'(CELL_COUNT)) : !range_ok);
      end
      S_GEO:    out_valid_nxt = (ph_r == 3'd4) && (xneg_r || ynum[51]);
      S_DIVX:   out_valid_nxt = div_done && (quo >= DIV_NW'(GRID_COLUMNS));
      S_DIVY:   out_valid_nxt = div_done && (quo >= DIV_NW'(GRID_ROWS));
      S_FINISH: out_valid_nxt = 1'b1;
      default:  out_valid_nxt = 1'b0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= 10'd100;
      thr_r       <= 16'd600;
      org_x_r     <= -16'sd10000;
      org_y_r     <= -16'sd20000;
      rlo_r       <= 16'd20;
      rhi_r       <= 16'd30000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_SIZE:  cell_size_r <= cfg_wdata[9:0];
        REG_HEIGHT_THR: thr_r       <= cfg_wdata;
        REG_ORIGIN_X:   org_x_r     <= $signed(cfg_wdata);
        REG_ORIGIN_Y:   org_y_r     <= $signed(cfg_wdata);
        REG_RANGE_LOW:  rlo_r       <= cfg_wdata;
        REG_RANGE_HIGH: rhi_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: state, working registers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      si_r        <= '0;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (start && !busy) begin
            item_r <= in_data;
            si_r   <= '0;
            ph_r   <= '0;
            if (in_data.mode) begin
              if (in_data.read_index < 17'(CELL_COUNT)) begin
                addr_r  <= in_data.read_index[ADDR_W-1:0];
                state_r <= S_RDWAIT;
              end else begin
                out_r.cell_index <= in_data.read_index;
                out_r.cell_value <= '0;
                out_r.status     <= ST_OUTSIDE;
              end
            end else if (!range_ok) begin
              out_r.cell_index <= '0;
              out_r.cell_value <= '0;
              out_r.status     <= ST_REJECTED;
            end else begin
              state_r <= S_SINE;
            end
          end
        end
        S_SINE: begin
          ph_r <= (ph_r == 3'd5) ? 3'd0 : ph_r + 3'd1;
          if (ph_r == 3'd0) begin
            t_r   <= t_new;
            neg_r <= ang[15];
          end
          if (ph_r == 3'd1) begin
            t2_r <= p_sh[15:0];
          end
          if (ph_r == 3'd5) begin
            sin_r[si_r] <= sine_val;
            si_r        <= si_r + 2'd1;
            if (si_r == 2'd3) begin
              state_r <= S_GEO;
            end
          end
        end
        S_GEO: begin
          ph_r <= (ph_r == 3'd4) ? 3'd0 : ph_r + 3'd1;
          if (ph_r == 3'd1) begin
            lower_r <= p_r < $signed({21'd0, thr_r, 15'd0});
          end
          if (ph_r == 3'd2) begin
            reach_r <= p_r[32:0];
          end
          if (ph_r == 3'd3) begin
            xneg_r <= xnum[51];
            xn_r   <= xnum[50:30];
          end
          if (ph_r == 3'd4) begin
            yn_r <= ynum[50:30];
            if (xneg_r || ynum[51]) begin
              out_r.cell_index <= '0;
              out_r.cell_value <= '0;
              out_r.status     <= ST_OUTSIDE;
              state_r          <= S_IDLE;
            end else begin
              state_r <= S_DIVX;
            end
          end
        end
        S_DIVX: begin
          if (div_done) begin
            if (quo < DIV_NW'(GRID_COLUMNS)) begin
              col_r   <= quo[COL_W-1:0];
              state_r <= S_DIVY;
            end else begin
              out_r.cell_index <= '0;
              out_r.cell_value <= '0;
              out_r.status     <= ST_OUTSIDE;
              state_r          <= S_IDLE;
            end
          end
        end
        S_DIVY: begin
          if (div_done) begin
            if (quo < DIV_NW'(GRID_ROWS)) begin
              addr_r  <= ADDR_W'(quo[ROW_W-1:0] * ADDR_W'(GRID_COLUMNS))
                         + ADDR_W'(col_r);
              state_r <= S_RDWAIT;
            end else begin
              out_r.cell_index <= '0;
              out_r.cell_value <= '0;
              out_r.status     <= ST_OUTSIDE;
              state_r          <= S_IDLE;
            end
          end
        end
        S_RDWAIT: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          out_r.cell_index <= 17'(addr_r);
          state_r          <= S_IDLE;
          if (item_r.mode) begin
            out_r.cell_value <= rd_data;
            out_r.status     <= ST_READ;
          end else begin
            out_r.cell_value <= new_val;
            out_r.status     <= lower_r ? ST_LOWERED : ST_RAISED;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE) || clr_busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
